@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the RTL; they compile away under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold on every clock edge outside reset.
`define ASSERT_PROP(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("assertion failed");
// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("assertion failed");
`else
`define ASSERT_PROP(lbl, prop)
`define ASSERT_NEVER(lbl, expr)
`endif

`endif

@@ hw/rtl/pbls_pkg.sv @@
// Types and constants of the power button long-press sequencer.
package pbls_pkg;

	localparam int TICK_W  = 32;
	localparam int CNT_W   = 8;
	localparam int STAGE_W = 3;
	localparam int CODE_W  = 3;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	// opcodes
	localparam logic [1:0] OP_EDGE = 2'd0;
	localparam logic [1:0] OP_POLL = 2'd1;
	localparam logic [1:0] OP_TAKE = 2'd2;

	// stages
	localparam logic [STAGE_W-1:0] ST_IDLE     = 3'd0;
	localparam logic [STAGE_W-1:0] ST_NORMAL   = 3'd1;
	localparam logic [STAGE_W-1:0] ST_LONG     = 3'd2;
	localparam logic [STAGE_W-1:0] ST_SHIP     = 3'd3;
	localparam logic [STAGE_W-1:0] ST_WARN     = 3'd4;
	localparam logic [STAGE_W-1:0] ST_IMMINENT = 3'd5;
	localparam logic [STAGE_W-1:0] ST_RELEASED = 3'd6;

	// event codes
	localparam logic [CODE_W-1:0] EV_NONE     = 3'd0;
	localparam logic [CODE_W-1:0] EV_SHIP     = 3'd1;
	localparam logic [CODE_W-1:0] EV_WARN     = 3'd2;
	localparam logic [CODE_W-1:0] EV_IMMINENT = 3'd3;
	localparam logic [CODE_W-1:0] EV_RELEASED = 3'd4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_STABLE_SAMPLES = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SHIP_PREP      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SHIP_WARN      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SHIP_IMMINENT  = 3'd4;

	// configuration reset values
	localparam logic [CNT_W-1:0]  STABLE_SAMPLES_RST = 8'd3;
	localparam logic [TICK_W-1:0] LONG_PRESS_RST     = 32'd100;
	localparam logic [TICK_W-1:0] SHIP_PREP_RST      = 32'd300;
	localparam logic [TICK_W-1:0] SHIP_WARN_RST      = 32'd500;
	localparam logic [TICK_W-1:0] SHIP_IMMINENT_RST  = 32'd700;

	typedef struct packed {
		logic [1:0]        opcode;
		logic              pin_level;
		logic [TICK_W-1:0] tick;
	} in_item_t;

	typedef struct packed {
		logic               due;
		logic [STAGE_W-1:0] stage;
		logic               press_active;
		logic               event_valid;
		logic [CODE_W-1:0]  event_code;
		logic [TICK_W-1:0]  event_time;
		logic [TICK_W-1:0]  event_hold;
		logic               event_dropped;
	} out_item_t;

endpackage

@@ hw/rtl/power_button_long_press_sequencer_top.sv @@
// Power button sequencer: an accepted item is registered in the input register,
// processed against the button state and its result held in an output register.
// One item per cycle is sustained while out_ready is high. Configuration writes
// take effect at the write edge and have no read-back.
`include "assert_macros.svh"

module power_button_long_press_sequencer_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  pbls_pkg::in_item_t              in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output pbls_pkg::out_item_t             out_data,
	input  logic                            cfg_we,
	input  logic [pbls_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pbls_pkg::CFG_DATA_W-1:0] cfg_data
);
	import pbls_pkg::*;

	// configuration
	logic [CNT_W-1:0]  stable_samples_q;
	logic [TICK_W-1:0] long_press_q, ship_prep_q, ship_warn_q, ship_imminent_q;

	// button state
	logic               active_q, pend_q, rel_pend_q, armed_q;
	logic               sample_level_q, debounced_q;
	logic [CNT_W-1:0]   stable_count_q;
	logic [TICK_W-1:0]  press_time_q, deadline_q;
	logic [STAGE_W-1:0] stage_q;
	logic [CODE_W-1:0]  mbox_code_q;
	logic [TICK_W-1:0]  mbox_time_q, mbox_hold_q;

	// pipeline
	logic      v_s1;
	in_item_t  item_s1;
	logic      out_valid_q;
	out_item_t out_data_q;
	logic      adv_s2;

	// next state
	logic               n_active, n_pend, n_rel_pend, n_armed;
	logic               n_sample_level, n_debounced;
	logic [CNT_W-1:0]   n_stable_count;
	logic [TICK_W-1:0]  n_press_time, n_deadline;
	logic [STAGE_W-1:0] n_stage;
	logic [CODE_W-1:0]  n_mbox_code;
	logic [TICK_W-1:0]  n_mbox_time, n_mbox_hold;
	out_item_t          res;

	logic [TICK_W-1:0]  hold_diff, elapsed, pub_hold;
	logic               reached, do_accept, do_release, do_advance, pub;
	logic [CODE_W-1:0]  pub_code;

	assign adv_s2    = !out_valid_q || out_ready;
	assign in_ready  = !v_s1 || adv_s2;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_samples_q <= STABLE_SAMPLES_RST;
			long_press_q     <= LONG_PRESS_RST;
			ship_prep_q      <= SHIP_PREP_RST;
			ship_warn_q      <= SHIP_WARN_RST;
			ship_imminent_q  <= SHIP_IMMINENT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_STABLE_SAMPLES: stable_samples_q <= cfg_data[CNT_W-1:0];
				REG_LONG_PRESS:     long_press_q     <= cfg_data[TICK_W-1:0];
				REG_SHIP_PREP:      ship_prep_q      <= cfg_data[TICK_W-1:0];
				REG_SHIP_WARN:      ship_warn_q      <= cfg_data[TICK_W-1:0];
				REG_SHIP_IMMINENT:  ship_imminent_q  <= cfg_data[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	assign hold_diff = item_s1.tick - press_time_q;
	assign elapsed   = item_s1.tick - deadline_q;
	assign reached   = !elapsed[TICK_W-1];

	always_comb begin
		n_active       = active_q;
		n_pend         = pend_q;
		n_rel_pend     = rel_pend_q;
		n_armed        = armed_q;
		n_sample_level = sample_level_q;
		n_debounced    = debounced_q;
		n_stable_count = stable_count_q;
		n_press_time   = press_time_q;
		n_deadline     = deadline_q;
		n_stage        = stage_q;
		n_mbox_code    = mbox_code_q;
		n_mbox_time    = mbox_time_q;
		n_mbox_hold    = mbox_hold_q;
		res            = '0;
		do_accept      = 1'b0;
		do_release     = 1'b0;
		do_advance     = 1'b0;
		pub            = 1'b0;
		pub_code       = EV_NONE;
		pub_hold       = hold_diff;

		case (item_s1.opcode)
			OP_EDGE: begin
				if (!item_s1.pin_level) begin
					if (!active_q) begin
						n_active     = 1'b1;
						n_pend       = 1'b1;
						n_rel_pend   = 1'b0;
						n_press_time = '0;
						n_armed      = 1'b0;
						n_deadline   = '0;
						n_stage      = ST_NORMAL;
					end
				end else if (active_q) begin
					n_rel_pend = 1'b1;
				end
			end
			OP_POLL: begin
				// debounce
				if (item_s1.pin_level == sample_level_q) begin
					if (stable_count_q < stable_samples_q) begin
						n_stable_count = stable_count_q + 1'b1;
					end
				end else begin
					n_sample_level = item_s1.pin_level;
					n_stable_count = CNT_W'(1);
				end
				if (n_stable_count >= stable_samples_q) begin
					n_debounced = n_sample_level;
				end
				res.due = pend_q || rel_pend_q || (active_q == n_debounced)
					|| (armed_q && reached);
				if (pend_q) begin
					if (!item_s1.pin_level) begin
						do_accept = 1'b1;
					end else if (rel_pend_q && n_debounced) begin
						do_release = 1'b1;
					end
				end else if (!active_q && !n_debounced) begin
					do_accept = 1'b1;
				end else begin
					if (rel_pend_q && !n_debounced) begin
						n_rel_pend = 1'b0;
					end
					if (active_q && n_debounced) begin
						do_release = 1'b1;
					end else if (active_q && armed_q && reached) begin
						do_advance = 1'b1;
					end
				end
			end
			OP_TAKE: begin
				if (mbox_code_q != EV_NONE) begin
					res.event_valid = 1'b1;
					res.event_code  = mbox_code_q;
					res.event_time  = mbox_time_q;
					res.event_hold  = mbox_hold_q;
					n_mbox_code     = EV_NONE;
					n_mbox_time     = '0;
					n_mbox_hold     = '0;
				end
			end
			default: ;
		endcase

		if (do_accept) begin
			n_active     = 1'b1;
			n_pend       = 1'b0;
			n_rel_pend   = 1'b0;
			n_press_time = item_s1.tick;
			n_stage      = ST_NORMAL;
			n_armed      = 1'b1;
			n_deadline   = item_s1.tick + long_press_q;
		end

		if (do_release) begin
			n_active   = 1'b0;
			n_pend     = 1'b0;
			n_rel_pend = 1'b0;
			n_armed    = 1'b0;
			n_deadline = '0;
			n_stage    = ST_RELEASED;
			// a press never accepted has no hold time
			pub_hold   = pend_q ? '0 : hold_diff;
			if (stage_q == ST_SHIP || stage_q == ST_WARN || stage_q == ST_IMMINENT) begin
				pub      = 1'b1;
				pub_code = EV_RELEASED;
			end
		end

		if (do_advance) begin
			case (stage_q)
				ST_NORMAL: begin
					n_stage    = ST_LONG;
					n_deadline = press_time_q + ship_prep_q;
				end
				ST_LONG: begin
					n_stage    = ST_SHIP;
					pub        = 1'b1;
					pub_code   = EV_SHIP;
					n_deadline = press_time_q + ship_warn_q;
				end
				ST_SHIP: begin
					n_stage    = ST_WARN;
					pub        = 1'b1;
					pub_code   = EV_WARN;
					n_deadline = press_time_q + ship_imminent_q;
				end
				ST_WARN: begin
					n_stage    = ST_IMMINENT;
					pub        = 1'b1;
					pub_code   = EV_IMMINENT;
					n_armed    = 1'b0;
					n_deadline = '0;
				end
				default: begin
					n_armed    = 1'b0;
					n_deadline = '0;
				end
			endcase
		end

		if (pub) begin
			res.event_dropped = (mbox_code_q != EV_NONE);
			n_mbox_code       = pub_code;
			n_mbox_time       = item_s1.tick;
			n_mbox_hold       = pub_hold;
		end

		res.stage        = n_stage;
		res.press_active = n_active;
	end

	// state and result update on each transfer into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q       <= 1'b0;
			pend_q         <= 1'b0;
			rel_pend_q     <= 1'b0;
			armed_q        <= 1'b0;
			sample_level_q <= 1'b1;
			debounced_q    <= 1'b1;
			stable_count_q <= STABLE_SAMPLES_RST;
			press_time_q   <= '0;
			deadline_q     <= '0;
			stage_q        <= ST_IDLE;
			mbox_code_q    <= EV_NONE;
			mbox_time_q    <= '0;
			mbox_hold_q    <= '0;
		end else if (adv_s2 && v_s1) begin
			active_q       <= n_active;
			pend_q         <= n_pend;
			rel_pend_q     <= n_rel_pend;
			armed_q        <= n_armed;
			sample_level_q <= n_sample_level;
			debounced_q    <= n_debounced;
			stable_count_q <= n_stable_count;
			press_time_q   <= n_press_time;
			deadline_q     <= n_deadline;
			stage_q        <= n_stage;
			mbox_code_q    <= n_mbox_code;
			mbox_time_q    <= n_mbox_time;
			mbox_hold_q    <= n_mbox_hold;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s2) begin
			out_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			out_data_q <= res;
		end
	end

	`ASSERT_PROP(a_armed_active, armed_q |-> active_q)
	`ASSERT_PROP(a_pend_active, (pend_q || rel_pend_q) |-> active_q)
	`ASSERT_PROP(a_armed_stage, armed_q |-> (stage_q >= ST_NORMAL && stage_q <= ST_WARN))
	`ASSERT_PROP(a_mbox_empty_clear,
		(mbox_code_q == EV_NONE) |-> (mbox_time_q == '0 && mbox_hold_q == '0))
	`ASSERT_NEVER(a_state_hold_no_transfer,
		!$past(adv_s2 && v_s1) && !$stable(stage_q) && $past(arst_n))

endmodule

@@ verif/pbls_sequencer_checker.sv @@
// Transfer monitor, button-sequencer predictor and result comparison for the power button block.
module pbls_sequencer_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  pbls_pkg::in_item_t              in_data,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  pbls_pkg::out_item_t             out_data,
	input  logic                            cfg_we,
	input  logic [pbls_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pbls_pkg::CFG_DATA_W-1:0] cfg_data,
	output int unsigned                     mismatches,
	output int unsigned                     outstanding,
	output int unsigned                     events_taken,
	output int unsigned                     overwrites
);
	timeunit 1ns;
	timeprecision 1ps;
	import pbls_pkg::*;

	// register copies
	logic [CNT_W-1:0]   cfg_stable;
	logic [TICK_W-1:0]  cfg_long, cfg_prep, cfg_warn, cfg_imm;

	// button state
	logic               active, press_pending, release_pending;
	logic               sample_level, debounced, armed;
	logic [CNT_W-1:0]   stable_count;
	logic [TICK_W-1:0]  press_time, deadline;
	logic [STAGE_W-1:0] stage_q;

	// event mailbox
	logic [CODE_W-1:0]  mb_code;
	logic [TICK_W-1:0]  mb_time, mb_hold;
	logic               overwrote;

	out_item_t          expected_results[$];
	out_item_t          want;

	function automatic logic deadline_reached(logic [TICK_W-1:0] now);
		logic [TICK_W-1:0] diff;
		diff = now - deadline;
		return !diff[TICK_W-1];
	endfunction

	function automatic void post_event(logic [CODE_W-1:0] code, logic [TICK_W-1:0] t,
			logic [TICK_W-1:0] hold);
		if (mb_code != EV_NONE)
			overwrote = 1'b1;
		mb_code = code;
		mb_time = t;
		mb_hold = hold;
	endfunction

	function automatic void start_hold(logic [TICK_W-1:0] now);
		active = 1'b1;
		press_pending = 1'b0;
		release_pending = 1'b0;
		press_time = now;
		stage_q = ST_NORMAL;
		armed = 1'b1;
		deadline = now + cfg_long;
	endfunction

	function automatic void end_hold(logic [TICK_W-1:0] now);
		logic [TICK_W-1:0] hold;
		logic              was_ship;
		// a press that was never accepted has no hold time
		hold = (active && !press_pending) ? now - press_time : '0;
		was_ship = (stage_q >= ST_SHIP) && (stage_q <= ST_IMMINENT);
		active = 1'b0;
		press_pending = 1'b0;
		release_pending = 1'b0;
		armed = 1'b0;
		deadline = '0;
		stage_q = ST_RELEASED;
		if (was_ship)
			post_event(EV_RELEASED, now, hold);
	endfunction

	function automatic out_item_t predict_result(in_item_t it);
		out_item_t         r;
		logic [TICK_W-1:0] now;
		logic [TICK_W-1:0] hold;
		r = '0;
		now = it.tick;
		overwrote = 1'b0;
		case (it.opcode)
		OP_EDGE: begin
			if (!it.pin_level) begin
				if (!active) begin
					active = 1'b1;
					press_pending = 1'b1;
					release_pending = 1'b0;
					press_time = '0;
					armed = 1'b0;
					deadline = '0;
					stage_q = ST_NORMAL;
				end
			end else if (active) begin
				release_pending = 1'b1;
			end
		end
		OP_POLL: begin
			if (it.pin_level == sample_level) begin
				if (stable_count < cfg_stable)
					stable_count = stable_count + 1'b1;
			end else begin
				sample_level = it.pin_level;
				stable_count = CNT_W'(1);
			end
			if (stable_count >= cfg_stable)
				debounced = sample_level;
			r.due = press_pending || release_pending || (!active && !debounced) ||
				(active && debounced) || (armed && deadline_reached(now));
			if (press_pending) begin
				if (!it.pin_level)
					start_hold(now);
				else if (release_pending && debounced)
					end_hold(now);
			end else if (!active && !debounced) begin
				start_hold(now);
			end else begin
				if (release_pending && !debounced)
					release_pending = 1'b0;
				if (active && debounced) begin
					end_hold(now);
				end else if (active && armed && deadline_reached(now)) begin
					hold = now - press_time;
					case (stage_q)
					ST_NORMAL: begin
						stage_q = ST_LONG;
						deadline = press_time + cfg_prep;
					end
					ST_LONG: begin
						stage_q = ST_SHIP;
						post_event(EV_SHIP, now, hold);
						deadline = press_time + cfg_warn;
					end
					ST_SHIP: begin
						stage_q = ST_WARN;
						post_event(EV_WARN, now, hold);
						deadline = press_time + cfg_imm;
					end
					ST_WARN: begin
						stage_q = ST_IMMINENT;
						post_event(EV_IMMINENT, now, hold);
						armed = 1'b0;
						deadline = '0;
					end
					default: begin
						armed = 1'b0;
						deadline = '0;
					end
					endcase
				end
			end
		end
		OP_TAKE: begin
			if (mb_code != EV_NONE) begin
				r.event_valid = 1'b1;
				r.event_code = mb_code;
				r.event_time = mb_time;
				r.event_hold = mb_hold;
				mb_code = EV_NONE;
				mb_time = '0;
				mb_hold = '0;
			end
		end
		default: ;
		endcase
		r.stage = stage_q;
		r.press_active = active;
		r.event_dropped = overwrote;
		return r;
	endfunction

	task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
		if (got_v !== exp_v) begin
			if (mismatches < 10)
				$display("%0t: %s mismatch, expected %h, got %h", $realtime, name, exp_v, got_v);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_stable = STABLE_SAMPLES_RST;
			cfg_long = LONG_PRESS_RST;
			cfg_prep = SHIP_PREP_RST;
			cfg_warn = SHIP_WARN_RST;
			cfg_imm = SHIP_IMMINENT_RST;
			active = 1'b0;
			press_pending = 1'b0;
			release_pending = 1'b0;
			sample_level = 1'b1;
			debounced = 1'b1;
			stable_count = STABLE_SAMPLES_RST;
			armed = 1'b0;
			press_time = '0;
			deadline = '0;
			stage_q = ST_IDLE;
			mb_code = EV_NONE;
			mb_time = '0;
			mb_hold = '0;
			expected_results.delete();
			mismatches = 0;
			events_taken = 0;
			overwrites = 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
				REG_STABLE_SAMPLES: cfg_stable = cfg_data[CNT_W-1:0];
				REG_LONG_PRESS:     cfg_long = cfg_data;
				REG_SHIP_PREP:      cfg_prep = cfg_data;
				REG_SHIP_WARN:      cfg_warn = cfg_data;
				REG_SHIP_IMMINENT:  cfg_imm = cfg_data;
				default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: result transfer with nothing expected: %h",
							$realtime, out_data);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					check_field("due", 32'(want.due), 32'(out_data.due));
					check_field("stage", 32'(want.stage), 32'(out_data.stage));
					check_field("press_active", 32'(want.press_active),
						32'(out_data.press_active));
					check_field("event_valid", 32'(want.event_valid),
						32'(out_data.event_valid));
					check_field("event_code", 32'(want.event_code), 32'(out_data.event_code));
					check_field("event_time", want.event_time, out_data.event_time);
					check_field("event_hold", want.event_hold, out_data.event_hold);
					check_field("event_dropped", 32'(want.event_dropped),
						32'(out_data.event_dropped));
					if (want.event_valid)
						events_taken++;
					if (want.event_dropped)
						overwrites++;
				end
			end
			if (in_valid && in_ready)
				expected_results.push_back(predict_result(in_data));
			outstanding <= expected_results.size();
		end
	end

endmodule

@@ verif/power_button_long_press_sequencer_top_tb.sv @@
// Stimulus, idling and verdict for the power button long-press sequencer.
module power_button_long_press_sequencer_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import pbls_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	in_item_t              in_data = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_item_t             out_data;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int unsigned mismatches, outstanding, events_taken, overwrites;
	int unsigned items_sent = 0;
	int unsigned stall_left = 0;
	bit          gaps_on = 1'b0;
	bit          stalls_on = 1'b0;
	logic [TICK_W-1:0] tick_now = '0;
	logic [CNT_W-1:0]  cur_stable = STABLE_SAMPLES_RST;
	logic [TICK_W-1:0] cur_imm = SHIP_IMMINENT_RST;

	power_button_long_press_sequencer_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	pbls_sequencer_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatches(mismatches),
		.outstanding(outstanding),
		.events_taken(events_taken),
		.overwrites(overwrites)
	);

	always #1 clk = ~clk;

	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// mostly no gap, some short ones, a few long ones
	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	always @(posedge clk) begin
		if (!stalls_on) begin
			out_ready <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else begin
			out_ready <= ($urandom_range(0, 2) != 0);
			stall_left <= idle_len();
		end
	end

	task automatic send(logic [1:0] op, logic lvl, logic [TICK_W-1:0] tick);
		in_item_t    it;
		bit          took;
		int unsigned gap;
		it.opcode = op;
		it.pin_level = lvl;
		it.tick = tick;
		in_data <= it;
		in_valid <= 1'b1;
		// sample ready mid-cycle, the transfer happens at the next edge
		do begin
			@(negedge clk);
			took = in_ready;
			@(posedge clk);
		end while (!took);
		items_sent++;
		if (gaps_on) begin
			gap = idle_len();
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		@(posedge clk);
	endtask

	task automatic cfg_put(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic configure(logic [CNT_W-1:0] stable, logic [TICK_W-1:0] lp,
			logic [TICK_W-1:0] sp, logic [TICK_W-1:0] sw, logic [TICK_W-1:0] si);
		wait_for_results();
		cfg_put(REG_STABLE_SAMPLES, {{(CFG_DATA_W-CNT_W){1'b0}}, stable});
		cfg_put(REG_LONG_PRESS, lp);
		cfg_put(REG_SHIP_PREP, sp);
		cfg_put(REG_SHIP_WARN, sw);
		cfg_put(REG_SHIP_IMMINENT, si);
		cfg_we <= 1'b0;
		cur_stable = stable;
		cur_imm = si;
	endtask

	task automatic advance_tick(logic [TICK_W-1:0] stride);
		if ($urandom_range(0, 29) == 0)
			tick_now += $urandom();
		else
			tick_now += $urandom_range(0, stride);
	endtask

	// one press held through the stages, with noise, then a release
	task automatic press_cycle();
		int unsigned       n, k, span;
		logic [TICK_W-1:0] stride;
		logic              lvl;
		span = (cur_imm > 20000) ? 20000 : cur_imm;
		n = cur_stable + $urandom_range(2, 40);
		stride = (span * 3) / n + 1;
		if ($urandom_range(0, 4) == 0)
			tick_now = {TICK_W{1'b1}} - $urandom_range(0, span);
		if ($urandom_range(0, 2) == 0)
			send(OP_EDGE, 1'b0, $urandom());
		for (k = 0; k < n; k++) begin
			advance_tick(stride);
			case ($urandom_range(0, 19))
			0: send(OP_TAKE, 1'($urandom_range(0, 1)), $urandom());
			1: send(OP_EDGE, 1'($urandom_range(0, 1)), $urandom());
			2: send(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), $urandom());
			3: send(OP_POLL, cur_stable <= 8, tick_now);
			default: send(OP_POLL, 1'b0, tick_now);
			endcase
		end
		if ($urandom_range(0, 1) == 0)
			send(OP_EDGE, 1'b1, $urandom());
		// a very slow debounce leaves the press open into the next phase
		n = ((cur_stable > 8) ? 8 : cur_stable) + $urandom_range(1, 4);
		for (k = 0; k < n; k++) begin
			advance_tick(stride);
			lvl = !(cur_stable <= 8 && $urandom_range(0, 9) == 0);
			send(OP_POLL, lvl, tick_now);
		end
		if ($urandom_range(0, 1) == 0)
			send(OP_TAKE, 1'($urandom_range(0, 1)), $urandom());
	endtask

	task automatic run_phase(int unsigned budget);
		int unsigned stop_at;
		stop_at = items_sent + budget;
		while (items_sent < stop_at) begin
			gaps_on = ($urandom_range(0, 3) != 0);
			stalls_on = ($urandom_range(0, 3) != 0);
			press_cycle();
			if ($urandom_range(0, 5) == 0)
				wait_for_results();
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty mailbox, unknown opcode, unaccepted press, wrapped deadlines,
		// overwrite, release after ship intent
		gaps_on = 1'b1;
		stalls_on = 1'b1;
		send(OP_TAKE, 1'b0, 32'h0);
		send(OP_UNUSED, 1'b1, 32'hFFFF_FFFF);
		send(OP_EDGE, 1'b0, 32'h0);
		send(OP_EDGE, 1'b1, 32'hFFFF_FFFF);
		send(OP_POLL, 1'b1, 32'h0);
		send(OP_POLL, 1'b0, 32'hFFFF_FF00);
		send(OP_POLL, 1'b0, 32'hFFFF_FF10);
		send(OP_POLL, 1'b0, 32'hFFFF_FF20);
		send(OP_POLL, 1'b0, 32'hFFFF_FFF0);
		send(OP_POLL, 1'b0, 32'h0000_0050);
		send(OP_POLL, 1'b0, 32'h0000_0150);
		send(OP_TAKE, 1'b1, 32'h0);
		send(OP_POLL, 1'b0, 32'h0000_0200);
		send(OP_POLL, 1'b0, 32'h0000_0300);
		send(OP_POLL, 1'b1, 32'h0000_0301);
		send(OP_POLL, 1'b1, 32'h0000_0302);
		send(OP_POLL, 1'b1, 32'h0000_0303);
		send(OP_TAKE, 1'b0, 32'hFFFF_FFFF);
		send(OP_TAKE, 1'b0, 32'h0);
		send(OP_EDGE, 1'b0, 32'h5555_AAAA);
		send(OP_POLL, 1'b0, 32'h1234_5678);
		send(OP_EDGE, 1'b1, 32'h0);
		send(OP_POLL, 1'b1, 32'h1234_5679);
		send(OP_UNUSED, 1'b0, 32'h0);
		wait_for_results();

		tick_now = $urandom();
		run_phase(90);
		configure(8'd1, 32'd1, 32'd2, 32'd3, 32'd4);
		run_phase(90);
		configure(8'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		run_phase(60);
		configure(8'd255, 32'd40, 32'd90, 32'd140, 32'd200);
		run_phase(1);
		configure(8'd2, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'hFFFF_FFFE);
		run_phase(40);
		repeat (3) begin
			configure(8'($urandom_range(1, 5)), $urandom_range(1, 40), $urandom_range(1, 80),
				$urandom_range(1, 120), $urandom_range(1, 160));
			run_phase(50);
		end

		wait_for_results();
		repeat (8) @(posedge clk);
		$display("Sent %0d items across eight register settings, checking every result field.",
			items_sent);
		$display("Mailbox events taken: %0d, overwrites of an untaken event: %0d.",
			events_taken, overwrites);
		if (mismatches == 0 && outstanding == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/pbls_pkg.sv
hw/rtl/power_button_long_press_sequencer_top.sv
verif/pbls_sequencer_checker.sv
verif/power_button_long_press_sequencer_top_tb.sv
